// ===== sv/aik_pkg.sv =====
// Shared constants, types and helper functions of the arm inverse kinematics block.
package aik_pkg;

    localparam int NUM_ARMS     = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int ARM_W        = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths.
    localparam int CW     = 34;   // CORDIC x and y
    localparam int ZW     = 25;   // CORDIC angle, 1/16384 degree
    localparam int AW     = 26;   // joint angle sums
    localparam int SW     = 36;   // triangle terms
    localparam int RAD_W  = 64;   // square root radicand
    localparam int ROOT_W = 32;
    localparam int REM_W  = 36;

    localparam logic signed [ZW-1:0] DEG90  = 25'sd1474560;
    localparam logic signed [AW-1:0] DEG360 = 26'sd5898240;
    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    // Command modes.
    localparam logic [1:0] MODE_GOTO_ALL  = 2'd0;
    localparam logic [1:0] MODE_MOVE_ALL  = 2'd1;
    localparam logic [1:0] MODE_GOTO_AXIS = 2'd2;
    localparam logic [1:0] MODE_MOVE_AXIS = 2'd3;
    localparam logic [1:0] AXIS_NONE      = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARM = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHLD_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ELBW_OFF  = 3'd4;

    // Multiplier operations, in issue order.
    localparam logic [2:0] OP_XX  = 3'd0;
    localparam logic [2:0] OP_YY  = 3'd1;
    localparam logic [2:0] OP_ZZ  = 3'd2;
    localparam logic [2:0] OP_L1  = 3'd3;
    localparam logic [2:0] OP_L2  = 3'd4;
    localparam logic [2:0] OP_SUM = 3'd5;
    localparam logic [2:0] OP_DIF = 3'd6;
    localparam logic [2:0] OP_PQ  = 3'd7;

    // Arctangent operations, in issue order.
    localparam logic [1:0] CD_BASE = 2'd0;
    localparam logic [1:0] CD_ELEV = 2'd1;
    localparam logic [1:0] CD_SHLD = 2'd2;
    localparam logic [1:0] CD_ELBW = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_LOAD, S_MUL_RUN, S_CHECK, S_SCALE,
        S_RT1_GO, S_RT1_WAIT, S_RT2_GO, S_RT2_WAIT,
        S_CD_GO, S_CD_WAIT, S_DONE
    } state_t;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

    function automatic logic [19:0] atan_step(input logic [4:0] i);
        logic [19:0] v;
        unique case (i)
            5'd0:  v = 20'd737280;
            5'd1:  v = 20'd435242;
            5'd2:  v = 20'd229970;
            5'd3:  v = 20'd116736;
            5'd4:  v = 20'd58595;
            5'd5:  v = 20'd29326;
            5'd6:  v = 20'd14667;
            5'd7:  v = 20'd7334;
            5'd8:  v = 20'd3667;
            5'd9:  v = 20'd1833;
            5'd10: v = 20'd917;
            5'd11: v = 20'd458;
            5'd12: v = 20'd229;
            5'd13: v = 20'd115;
            5'd14: v = 20'd57;
            5'd15: v = 20'd29;
            5'd16: v = 20'd14;
            5'd17: v = 20'd7;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-$signed(e)) : e;
    endfunction

    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15]) r = v[16] ? 16'sh8000 : 16'sh7FFF;
        else r = v[15:0];
        return r;
    endfunction

    // Round half up to 1/64 degree, add the joint offset and saturate.
    function automatic logic signed [15:0] joint_out(input logic signed [AW-1:0] a,
                                                     input logic signed [14:0] off);
        logic signed [AW-1:0] r;
        logic signed [AW-9:0] q;
        logic signed [AW-8:0] v;
        logic signed [15:0] s;
        r = a + AW'(128);
        q = r[AW-1:8];
        v = {q[AW-9], q} + {{(AW-7-15){off[14]}}, off};
        if (v > 19'sd32767) s = 16'sh7FFF;
        else if (v < -19'sd32768) s = 16'sh8000;
        else s = v[15:0];
        return s;
    endfunction

endpackage

// ===== sv/arm_inverse_kinematics.sv =====
// Top level of the three-link arm inverse kinematics solver.
//
//   channel   direction  handshake            payload
//   command   in         in_valid/in_ready    mode, arm_index, axis, x/y/z_value, axis_value
//   result    out        out_valid/out_ready  base/shoulder/elbow_angle, status
//   config    in         cfg_we               cfg_index, cfg_data
//
// A solved command runs seven serial squarings and one product, two square roots
// and four CORDIC runs, plus one normalizing shift at a time of the triangle terms
// and of each CORDIC input; small coordinates or very short links take more shifts.
// A bad arm index skips the work, an unreachable target returns after the squarings.
// Reset clears all stored targets at once and loads the default lengths and offsets.
// One command is in work at a time; the next transfer is taken as soon as the
// result sits in the output register, even while that result is stalled.
module arm_inverse_kinematics (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic [2:0]                         arm_index,
    input  logic [1:0]                         axis,
    input  logic signed [15:0]                 x_value,
    input  logic signed [15:0]                 y_value,
    input  logic signed [15:0]                 z_value,
    input  logic signed [15:0]                 axis_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [15:0]                 base_angle,
    output logic signed [15:0]                 shoulder_angle,
    output logic signed [15:0]                 elbow_angle,
    output logic [1:0]                         status,
    input  logic                               cfg_we,
    input  logic [aik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aik_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import aik_pkg::*;

    state_t state_reg, state_next;

    // Configuration.
    logic [15:0]        upper_len_reg, fore_len_reg;
    logic signed [14:0] base_off_reg, shld_off_reg, elbw_off_reg;

    // Stored targets, one x/y/z triple per arm.
    logic signed [15:0] pts_reg [NUM_ARMS][3];

    // Sequencer counters.
    logic [2:0] mop_reg;
    logic [4:0] mcnt_reg;
    logic [1:0] cop_reg;
    logic       out_valid_reg;

    // Working payload.
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic [1:0]         res_status_reg;
    logic [31:0]        mcand_reg;
    logic [63:0]        prod_reg;
    logic [33:0]        sq_reg [7];
    logic signed [SW-1:0] pp_reg, qq_reg, n_reg, m_reg;
    logic [31:0]        xy_reg;
    logic [28:0]        a4_reg;
    logic [27:0]        rxy_reg;
    logic signed [AW-1:0] base_acc_reg, sh_acc_reg, el_acc_reg;
    logic signed [15:0] base_out_reg, shld_out_reg, elbw_out_reg;
    logic [1:0]         status_out_reg;

    logic in_xfer, bad_arm, out_load;
    logic [ARM_W-1:0] arm_sel;
    logic signed [15:0] cur [3];
    logic signed [15:0] in_v [3];
    logic signed [15:0] nxt [3];

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign bad_arm  = ({1'b0, arm_index} >= 4'(NUM_ARMS));
    assign arm_sel  = arm_index[ARM_W-1:0];

    // New target point for the addressed arm. Relative moves saturate.
    always_comb
    begin
        in_v[0] = x_value;
        in_v[1] = y_value;
        in_v[2] = z_value;
        for (int c = 0; c < 3; c++)
        begin
            cur[c] = pts_reg[arm_sel][c];
            nxt[c] = cur[c];
        end
        unique case (mode)
            MODE_GOTO_ALL:
                for (int c = 0; c < 3; c++) nxt[c] = in_v[c];
            MODE_MOVE_ALL:
                for (int c = 0; c < 3; c++)
                    nxt[c] = sat17({cur[c][15], cur[c]} + {in_v[c][15], in_v[c]});
            MODE_GOTO_AXIS:
                if (axis != AXIS_NONE) nxt[axis] = axis_value;
            MODE_MOVE_AXIS:
                if (axis != AXIS_NONE)
                    nxt[axis] = sat17({cur[axis][15], cur[axis]} +
                                      {axis_value[15], axis_value});
        endcase
    end

    // Multiplier operand selection and one shift-add step.
    logic [31:0] mul_a, mul_b;
    logic [16:0] len_sum;
    logic [15:0] len_dif;
    logic [32:0] msum;
    logic [63:0] mul_res;

    always_comb
    begin
        len_sum = {1'b0, upper_len_reg} + {1'b0, fore_len_reg};
        len_dif = (upper_len_reg >= fore_len_reg) ? (upper_len_reg - fore_len_reg)
                                                  : (fore_len_reg - upper_len_reg);
        mul_a = '0;
        unique case (mop_reg)
            OP_XX:  mul_a = {15'b0, abs16(px_reg)};
            OP_YY:  mul_a = {15'b0, abs16(py_reg)};
            OP_ZZ:  mul_a = {15'b0, abs16(pz_reg)};
            OP_L1:  mul_a = {16'b0, upper_len_reg};
            OP_L2:  mul_a = {16'b0, fore_len_reg};
            OP_SUM: mul_a = {15'b0, len_sum};
            OP_DIF: mul_a = {16'b0, len_dif};
            OP_PQ:  mul_a = {3'b0, pp_reg[28:0]};
        endcase
        mul_b   = (mop_reg == OP_PQ) ? {3'b0, qq_reg[28:0]} : mul_a;
        msum    = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, mcand_reg} : 33'd0);
        mul_res = {msum, prod_reg[31:1]};
    end

    // Triangle terms and the reach test.
    logic [33:0] r2;
    logic        unreach;
    always_comb
    begin
        r2 = sq_reg[OP_XX] + sq_reg[OP_YY] + sq_reg[OP_ZZ];
        unreach = (upper_len_reg == '0) || (fore_len_reg == '0) || (r2 == '0) ||
                  (r2 > sq_reg[OP_SUM]) || (r2 < sq_reg[OP_DIF]);
    end

    // Common scaling of the four terms into [2^28, 2^29).
    logic [SW-1:0] abs_pp, abs_qq, abs_n, abs_m, mx_a, mx_b, mx;
    logic scale_dn, scale_up;
    always_comb
    begin
        abs_pp   = pp_reg[SW-1] ? SW'(-pp_reg) : SW'(pp_reg);
        abs_qq   = qq_reg[SW-1] ? SW'(-qq_reg) : SW'(qq_reg);
        abs_n    = n_reg[SW-1]  ? SW'(-n_reg)  : SW'(n_reg);
        abs_m    = m_reg[SW-1]  ? SW'(-m_reg)  : SW'(m_reg);
        mx_a     = (abs_pp > abs_qq) ? abs_pp : abs_qq;
        mx_b     = (abs_n > abs_m) ? abs_n : abs_m;
        mx       = (mx_a > mx_b) ? mx_a : mx_b;
        scale_dn = |mx[SW-1:29];
        scale_up = ~|mx[SW-1:28];
    end

    // Square root and arctangent units.
    logic              rt_start, rt_done;
    logic [RAD_W-1:0]  rt_rad;
    logic [ROOT_W-1:0] rt_root;
    logic              cd_start, cd_done;
    logic signed [CW-1:0] cd_y, cd_x;
    logic signed [ZW-1:0] cd_angle;

    aik_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (rt_rad),
        .done     (rt_done),
        .root     (rt_root)
    );

    aik_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .y_in  (cd_y),
        .x_in  (cd_x),
        .done  (cd_done),
        .angle (cd_angle)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_xfer) state_next = bad_arm ? S_DONE : S_MUL_LOAD;
            S_MUL_LOAD: state_next = S_MUL_RUN;
            S_MUL_RUN:
                if (mcnt_reg == '1)
                begin
                    if (mop_reg == OP_DIF) state_next = S_CHECK;
                    else if (mop_reg == OP_PQ) state_next = S_RT1_GO;
                    else state_next = S_MUL_LOAD;
                end
            S_CHECK:    state_next = unreach ? S_DONE : S_SCALE;
            S_SCALE:    if (!scale_dn && !scale_up) state_next = S_MUL_LOAD;
            S_RT1_GO:   state_next = S_RT1_WAIT;
            S_RT1_WAIT: if (rt_done) state_next = S_RT2_GO;
            S_RT2_GO:   state_next = S_RT2_WAIT;
            S_RT2_WAIT: if (rt_done) state_next = S_CD_GO;
            S_CD_GO:    state_next = S_CD_WAIT;
            S_CD_WAIT:  if (cd_done) state_next = (cop_reg == CD_ELBW) ? S_DONE : S_CD_GO;
            S_DONE:     if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Unit controls and operands.
    always_comb
    begin
        rt_start = (state_reg == S_RT1_GO) || (state_reg == S_RT2_GO);
        rt_rad   = (state_reg == S_RT1_GO) ? prod_reg : {8'b0, xy_reg, 24'b0};
        cd_start = (state_reg == S_CD_GO);
        out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        unique case (cop_reg)
            CD_BASE:
            begin
                cd_y = {{(CW-16){py_reg[15]}}, py_reg};
                cd_x = {{(CW-16){px_reg[15]}}, px_reg};
            end
            CD_ELEV:
            begin
                cd_y = {{(CW-28){pz_reg[15]}}, pz_reg, 12'b0};
                cd_x = {{(CW-28){1'b0}}, rxy_reg};
            end
            CD_SHLD:
            begin
                cd_y = {{(CW-29){1'b0}}, a4_reg};
                cd_x = n_reg[CW-1:0];
            end
            CD_ELBW:
            begin
                cd_y = {{(CW-29){1'b0}}, a4_reg};
                cd_x = m_reg[CW-1:0];
            end
        endcase
    end

    // Control state, configuration and stored targets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mop_reg       <= OP_XX;
            mcnt_reg      <= '0;
            cop_reg       <= CD_BASE;
            out_valid_reg <= 1'b0;
            upper_len_reg <= 16'd1600;
            fore_len_reg  <= 16'd1600;
            base_off_reg  <= '0;
            shld_off_reg  <= '0;
            elbw_off_reg  <= '0;
            for (int a = 0; a < NUM_ARMS; a++)
                for (int c = 0; c < 3; c++) pts_reg[a][c] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_UPPER_LEN: upper_len_reg <= cfg_data;
                    REG_FORE_LEN:  fore_len_reg  <= cfg_data;
                    REG_BASE_OFF:  base_off_reg  <= cfg_data[14:0];
                    REG_SHLD_OFF:  shld_off_reg  <= cfg_data[14:0];
                    REG_ELBW_OFF:  elbw_off_reg  <= cfg_data[14:0];
                    default: ;
                endcase
            end

            if (in_xfer && !bad_arm)
                for (int c = 0; c < 3; c++) pts_reg[arm_sel][c] <= nxt[c];

            if (in_xfer) mop_reg <= OP_XX;
            else if (state_reg == S_MUL_RUN && mcnt_reg == '1 && mop_reg != OP_PQ)
                mop_reg <= mop_reg + 3'd1;
            else if (state_reg == S_SCALE) mop_reg <= OP_PQ;

            if (state_reg == S_MUL_RUN) mcnt_reg <= mcnt_reg + 5'd1;
            else mcnt_reg <= '0;

            if (state_reg == S_RT2_WAIT) cop_reg <= CD_BASE;
            else if (state_reg == S_CD_WAIT && cd_done) cop_reg <= cop_reg + 2'd1;

            if (out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_xfer)
                begin
                    px_reg <= nxt[0];
                    py_reg <= nxt[1];
                    pz_reg <= nxt[2];
                    res_status_reg <= bad_arm ? ST_BAD_ARM : ST_OK;
                end
            S_MUL_LOAD:
            begin
                prod_reg  <= {32'b0, mul_b};
                mcand_reg <= mul_a;
            end
            S_MUL_RUN:
            begin
                prod_reg <= mul_res;
                if (mcnt_reg == '1 && mop_reg != OP_PQ) sq_reg[mop_reg] <= mul_res[33:0];
            end
            S_CHECK:
            begin
                if (unreach) res_status_reg <= ST_UNREACH;
                pp_reg <= $signed({2'b00, sq_reg[OP_SUM]}) - $signed({2'b00, r2});
                qq_reg <= $signed({2'b00, r2}) - $signed({2'b00, sq_reg[OP_DIF]});
                n_reg  <= $signed({2'b00, sq_reg[OP_L1]}) + $signed({2'b00, r2})
                        - $signed({2'b00, sq_reg[OP_L2]});
                m_reg  <= $signed({2'b00, sq_reg[OP_L1]}) + $signed({2'b00, sq_reg[OP_L2]})
                        - $signed({2'b00, r2});
                xy_reg <= 32'(sq_reg[OP_XX] + sq_reg[OP_YY]);
            end
            S_SCALE:
                if (scale_dn)
                begin
                    pp_reg <= pp_reg >>> 1;
                    qq_reg <= qq_reg >>> 1;
                    n_reg  <= n_reg >>> 1;
                    m_reg  <= m_reg >>> 1;
                end
                else if (scale_up)
                begin
                    pp_reg <= pp_reg <<< 1;
                    qq_reg <= qq_reg <<< 1;
                    n_reg  <= n_reg <<< 1;
                    m_reg  <= m_reg <<< 1;
                end
            S_RT1_WAIT: if (rt_done) a4_reg <= rt_root[28:0];
            S_RT2_WAIT: if (rt_done) rxy_reg <= rt_root[27:0];
            S_CD_WAIT:
                if (cd_done)
                begin
                    unique case (cop_reg)
                        CD_BASE:
                            // Outside the right half plane the base is kept non-negative.
                            if (!(px_reg > 16'sd0) && cd_angle[ZW-1])
                                base_acc_reg <= AW'(cd_angle) + DEG360;
                            else
                                base_acc_reg <= AW'(cd_angle);
                        CD_ELEV: sh_acc_reg <= AW'(cd_angle);
                        CD_SHLD: sh_acc_reg <= sh_acc_reg + AW'(cd_angle);
                        CD_ELBW: el_acc_reg <= AW'(cd_angle) - AW'(DEG90);
                    endcase
                end
            S_DONE:
                if (out_load)
                begin
                    status_out_reg <= res_status_reg;
                    if (res_status_reg == ST_OK)
                    begin
                        base_out_reg <= joint_out(base_acc_reg, base_off_reg);
                        shld_out_reg <= joint_out(sh_acc_reg, shld_off_reg);
                        elbw_out_reg <= joint_out(el_acc_reg, elbw_off_reg);
                    end
                    else
                    begin
                        base_out_reg <= '0;
                        shld_out_reg <= '0;
                        elbw_out_reg <= '0;
                    end
                end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign base_angle     = base_out_reg;
    assign shoulder_angle = shld_out_reg;
    assign elbow_angle    = elbw_out_reg;
    assign status         = status_out_reg;

endmodule

// ===== sv/aik_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module aik_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [aik_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [aik_pkg::ROOT_W-1:0] root
);
    import aik_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sv/aik_cordic.sv =====
// Vectoring CORDIC arctangent with input normalization, one step per cycle.
module aik_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [aik_pkg::CW-1:0] y_in,
    input  logic signed [aik_pkg::CW-1:0] x_in,
    output logic                          done,
    output logic signed [aik_pkg::ZW-1:0] angle
);
    import aik_pkg::*;

    cstate_t cstate_reg, cstate_next;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           i_reg;
    logic                 done_reg;

    logic [CW-1:0] ax, ay, pk;
    logic pk_zero, pk_hi, pk_lo;
    logic norm_shr, norm_shl, norm_fin, norm_zero, iter_step;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] tab;

    always_comb
    begin
        ax      = x_reg[CW-1] ? CW'(-x_reg) : CW'(x_reg);
        ay      = y_reg[CW-1] ? CW'(-y_reg) : CW'(y_reg);
        pk      = (ax > ay) ? ax : ay;
        pk_zero = (pk == '0);
        pk_hi   = |pk[CW-1:30];
        pk_lo   = ~|pk[CW-1:29];
        dx      = y_reg >>> i_reg;
        dy      = x_reg >>> i_reg;
        tab     = $signed({5'b0, atan_step(i_reg)});
    end

    always_comb
    begin
        cstate_next = cstate_reg;
        unique case (cstate_reg)
            C_IDLE: if (start) cstate_next = C_NORM;
            C_NORM: if (pk_zero) cstate_next = C_IDLE;
                    else if (!pk_hi && !pk_lo) cstate_next = C_ITER;
            C_ITER: if (i_reg == LAST_STEP) cstate_next = C_IDLE;
            default: cstate_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        norm_zero = (cstate_reg == C_NORM) && pk_zero;
        norm_shr  = (cstate_reg == C_NORM) && !pk_zero && pk_hi;
        norm_shl  = (cstate_reg == C_NORM) && !pk_zero && pk_lo;
        norm_fin  = (cstate_reg == C_NORM) && !pk_zero && !pk_hi && !pk_lo;
        iter_step = (cstate_reg == C_ITER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= C_IDLE;
            done_reg   <= 1'b0;
            i_reg      <= '0;
        end
        else
        begin
            cstate_reg <= cstate_next;
            done_reg   <= norm_zero || (iter_step && i_reg == LAST_STEP);
            if (norm_fin) i_reg <= '0;
            else if (iter_step) i_reg <= i_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cstate_reg == C_IDLE && start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
        else if (norm_zero)
        begin
            z_reg <= '0;
        end
        else if (norm_shr)
        begin
            x_reg <= x_reg >>> 1;
            y_reg <= y_reg >>> 1;
        end
        else if (norm_shl)
        begin
            x_reg <= x_reg <<< 1;
            y_reg <= y_reg <<< 1;
        end
        else if (norm_fin)
        begin
            // A vector in the left half plane is turned by a quarter first.
            if (x_reg[CW-1])
            begin
                if (!y_reg[CW-1])
                begin
                    x_reg <= y_reg;
                    y_reg <= -x_reg;
                    z_reg <= DEG90;
                end
                else
                begin
                    x_reg <= -y_reg;
                    y_reg <= x_reg;
                    z_reg <= -DEG90;
                end
            end
            else
            begin
                z_reg <= '0;
            end
        end
        else if (iter_step)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + tab;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - tab;
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

// ===== sv/aik_checker.sv =====
// Port-level checks of the arm inverse kinematics block and their binding.
module aik_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [15:0]  base_angle,
    input logic signed [15:0]  shoulder_angle,
    input logic signed [15:0]  elbow_angle,
    input logic [1:0]          status
);
    import aik_pkg::*;

    // A command in work blocks the next transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a command was in work");

    // A fresh result only comes out of a busy cycle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // Error results carry zero angles.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
            base_angle == 16'sd0 && shoulder_angle == 16'sd0 && elbow_angle == 16'sd0)
        else $error("error result with nonzero angles");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(base_angle) && $stable(shoulder_angle) && $stable(elbow_angle))
        else $error("stalled result changed");

endmodule

bind arm_inverse_kinematics aik_checker u_aik_checker (.*);

// ===== verif/tb_arm_inverse_kinematics.sv =====
// Self-checking testbench for the arm inverse kinematics solver.
module tb_arm_inverse_kinematics;
    timeunit 1ns;
    timeprecision 1ps;

    import aik_pkg::*;

    // One command as it is presented on the input channel.
    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         arm_index;
        logic [1:0]         axis;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
        logic signed [15:0] axis_value;
    } command_t;

    // One solved set of servo angles with its status.
    typedef struct packed {
        logic signed [15:0] base_angle;
        logic signed [15:0] shoulder_angle;
        logic signed [15:0] elbow_angle;
        logic [1:0]         status;
    } servo_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] mode;
    logic [2:0] arm_index;
    logic [1:0] axis;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] z_value;
    logic signed [15:0] axis_value;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] base_angle;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic [1:0] status;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    arm_inverse_kinematics i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .arm_index      (arm_index),
        .axis           (axis),
        .x_value        (x_value),
        .y_value        (y_value),
        .z_value        (z_value),
        .axis_value     (axis_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .base_angle     (base_angle),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Angle constants of the solver, in 1/16384 degree.
    localparam longint QUARTER_TURN = 64'sd1474560;
    localparam longint FULL_TURN    = 64'sd5898240;

    // Predictor state: the stored target of every arm and the shadow registers.
    longint target_pos [NUM_ARMS][3];
    longint upper_len;
    longint fore_len;
    longint joint_off [3];

    command_t      command_queue [$];
    servo_result_t servo_expected [$];
    int            mismatch_count;
    int            pending_commands;

    // Burst and stall shaping for the two channels.
    int  burst_left;
    int  gap_left;
    int  stall_left;
    int  flow_left;
    bit  stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint larger_mag(longint a, longint b);
        return (mag(a) > mag(b)) ? mag(a) : mag(b);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Integer square root by the bit-pair method, floor of the true root.
    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return longint'(root);
    endfunction

    // Vectoring CORDIC arctangent in 1/16384 degree; the origin gives zero.
    function automatic longint arctan2(longint y, longint x);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (larger_mag(x, y) == 0)
            return 0;
        while (larger_mag(x, y) >= (64'sd1 << 30))
        begin
            x = floor_shift(x, 1);
            y = floor_shift(y, 1);
        end
        while (larger_mag(x, y) < (64'sd1 << 29))
        begin
            x = x * 2;
            y = y * 2;
        end
        // Left half plane: rotate by a quarter turn first.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                ang = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                ang = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + longint'(atan_step(5'(i)));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - longint'(atan_step(5'(i)));
            end
        end
        return ang;
    endfunction

    // Rounds an angle to 1/64 degree, adds the joint offset and saturates.
    function automatic logic signed [15:0] servo_angle(longint a, int joint);
        return 16'(clamp16(floor_shift(a + 128, 8) + joint_off[joint]));
    endfunction

    // Applies one command to the stored targets and solves the arm.
    function automatic servo_result_t solve_command(command_t c);
        servo_result_t r;
        longint x, y, z, l1, l2, r2, s, d, n, m, pp, qq, mx, a4;
        longint base, sh, el;
        r = '0;
        if (c.arm_index >= NUM_ARMS)
        begin
            r.status = ST_BAD_ARM;
            return r;
        end
        case (c.mode)
            MODE_GOTO_ALL:
            begin
                target_pos[c.arm_index][0] = c.x_value;
                target_pos[c.arm_index][1] = c.y_value;
                target_pos[c.arm_index][2] = c.z_value;
            end
            MODE_MOVE_ALL:
            begin
                target_pos[c.arm_index][0] = clamp16(target_pos[c.arm_index][0] + c.x_value);
                target_pos[c.arm_index][1] = clamp16(target_pos[c.arm_index][1] + c.y_value);
                target_pos[c.arm_index][2] = clamp16(target_pos[c.arm_index][2] + c.z_value);
            end
            default:
            begin
                // The unused axis code leaves the target as it stands.
                if (c.axis != AXIS_NONE)
                begin
                    if (c.mode == MODE_GOTO_AXIS)
                        target_pos[c.arm_index][c.axis] = c.axis_value;
                    else
                        target_pos[c.arm_index][c.axis] =
                            clamp16(target_pos[c.arm_index][c.axis] + c.axis_value);
                end
            end
        endcase
        x = target_pos[c.arm_index][0];
        y = target_pos[c.arm_index][1];
        z = target_pos[c.arm_index][2];
        l1 = upper_len;
        l2 = fore_len;
        r2 = x * x + y * y + z * z;
        s = (l1 + l2) * (l1 + l2);
        d = (l1 - l2) * (l1 - l2);
        if (l1 == 0 || l2 == 0 || r2 == 0 || r2 > s || r2 < d)
        begin
            r.status = ST_UNREACH;
            return r;
        end
        n = l1 * l1 + r2 - l2 * l2;
        m = l1 * l1 + l2 * l2 - r2;
        pp = s - r2;
        qq = r2 - d;
        // Common power-of-two scaling of the triangle terms.
        mx = larger_mag(larger_mag(pp, qq), larger_mag(n, m));
        while (mx >= (64'sd1 << 29))
        begin
            pp = floor_shift(pp, 1);
            qq = floor_shift(qq, 1);
            n = floor_shift(n, 1);
            m = floor_shift(m, 1);
            mx = larger_mag(larger_mag(pp, qq), larger_mag(n, m));
        end
        while (mx > 0 && mx < (64'sd1 << 28))
        begin
            pp = pp * 2;
            qq = qq * 2;
            n = n * 2;
            m = m * 2;
            mx = mx * 2;
        end
        a4 = int_sqrt(64'(pp) * 64'(qq));
        if (x == 0 && y == 0)
            base = 0;
        else
        begin
            base = arctan2(y, x);
            if (x <= 0 && base < 0)
                base = base + FULL_TURN;
        end
        sh = arctan2(z * 4096, int_sqrt(64'(x * x + y * y) << 24)) + arctan2(a4, n);
        el = arctan2(a4, m) - QUARTER_TURN;
        r.base_angle = servo_angle(base, 0);
        r.shoulder_angle = servo_angle(sh, 1);
        r.elbow_angle = servo_angle(el, 2);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Driver: presents queued commands in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= '0;
            arm_index <= '0;
            axis <= '0;
            x_value <= '0;
            y_value <= '0;
            z_value <= '0;
            axis_value <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                servo_expected.push_back(solve_command(
                    {mode, arm_index, axis, x_value, y_value, z_value, axis_value}));
                pending_commands--;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (command_queue.size() > 0)
                begin
                    {mode, arm_index, axis, x_value, y_value, z_value, axis_value}
                        <= command_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 6);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation and stalls
    // the result channel in runs of its own.
    always @(posedge clk or negedge rst_n)
    begin
        servo_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            flow_left = 0;
            stall_mode = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (servo_expected.size() == 0)
                    report_mismatch("unexpected result, status", status, 0);
                else
                begin
                    want = servo_expected.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (base_angle !== want.base_angle)
                        report_mismatch("base_angle", base_angle, want.base_angle);
                    if (shoulder_angle !== want.shoulder_angle)
                        report_mismatch("shoulder_angle", shoulder_angle, want.shoulder_angle);
                    if (elbow_angle !== want.elbow_angle)
                        report_mismatch("elbow_angle", elbow_angle, want.elbow_angle);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (flow_left > 0)
            begin
                flow_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                stall_mode = ~stall_mode;
                if (stall_mode)
                    stall_left = $urandom_range(0, 700);
                else
                    flow_left = $urandom_range(1, 2000);
                out_ready <= ~stall_mode;
            end
        end
    end

    task automatic add_command(logic [1:0] md, logic [2:0] arm, logic [1:0] ax,
                               logic [15:0] xv, logic [15:0] yv, logic [15:0] zv,
                               logic [15:0] av);
        command_t c;
        c = {md, arm, ax, xv, yv, zv, av};
        command_queue.push_back(c);
        pending_commands++;
    endtask

    // Writes one register; only called while the solver is idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_UPPER_LEN: upper_len = value;
            REG_FORE_LEN:  fore_len = value;
            REG_BASE_OFF:  joint_off[0] = longint'($signed(value[14:0]));
            REG_SHLD_OFF:  joint_off[1] = longint'($signed(value[14:0]));
            default:       joint_off[2] = longint'($signed(value[14:0]));
        endcase
    endtask

    // Waits until every queued command was taken and every result has come back.
    task automatic drain;
        while (pending_commands > 0 || servo_expected.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Random command: four in ten are targets built from the arm lengths, the rest
    // relative moves, single-axis writes, bad arms and raw noise.
    task automatic add_random_command;
        int kind;
        longint reach;
        logic [15:0] xv, yv, zv, av;
        kind = $urandom_range(0, 9);
        reach = upper_len + fore_len;
        if (reach > 32767)
            reach = 32767;
        if (reach < 1)
            reach = 1;
        xv = 16'($signed($urandom_range(0, 2 * reach)) - reach) >>> $urandom_range(0, 1);
        yv = 16'($signed($urandom_range(0, 2 * reach)) - reach) >>> $urandom_range(0, 1);
        zv = 16'($signed($urandom_range(0, 2 * reach)) - reach) >>> $urandom_range(0, 1);
        av = 16'($urandom_range(0, 255)) - 16'd128;
        if (kind <= 3)
            add_command(MODE_GOTO_ALL, 3'($urandom_range(0, NUM_ARMS - 1)), 2'($urandom),
                        16'($signed(xv) * 10 / 17), 16'($signed(yv) * 10 / 17),
                        16'($signed(zv) * 10 / 17), av);
        else if (kind <= 5)
            add_command(MODE_MOVE_ALL, 3'($urandom_range(0, NUM_ARMS - 1)), 2'($urandom),
                        16'($signed(xv) >>> 3), 16'($signed(yv) >>> 3),
                        16'($signed(zv) >>> 3), av);
        else if (kind <= 7)
            add_command(2'($urandom_range(2, 3)), 3'($urandom_range(0, NUM_ARMS - 1)),
                        2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        ($urandom_range(0, 1) != 0) ? av : xv);
        else
            add_command(2'($urandom), 3'($urandom), 2'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        pending_commands = 0;
        foreach (target_pos[a, c])
            target_pos[a][c] = 0;
        upper_len = 1600;
        fore_len = 1600;
        joint_off[0] = 0;
        joint_off[1] = 0;
        joint_off[2] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset lengths: origin, reach limits, the second, third and fourth
        // quadrants, the z axis, saturated moves, axis writes and the unused axis, bad arms.
        add_command(MODE_GOTO_AXIS, 3'd0, AXIS_NONE, 0, 0, 0, 0);
        add_command(MODE_GOTO_ALL, 3'd0, 2'd0, 16'sd3200, 0, 0, 0);
        add_command(MODE_GOTO_ALL, 3'd1, 2'd0, -16'sd1000, 16'sd1000, 16'sd500, 0);
        add_command(MODE_GOTO_ALL, 3'd2, 2'd0, -16'sd1000, -16'sd1200, -16'sd300, 0);
        add_command(MODE_GOTO_ALL, 3'd3, 2'd0, 16'sd900, -16'sd900, 16'sd2000, 0);
        add_command(MODE_GOTO_ALL, 3'd1, 2'd0, 0, 0, 16'sd2500, 0);
        add_command(MODE_GOTO_ALL, 3'd1, 2'd0, -16'sd2000, 0, 16'sd100, 0);
        add_command(MODE_GOTO_ALL, 3'd0, 2'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
        add_command(MODE_MOVE_ALL, 3'd0, 2'd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 0);
        add_command(MODE_GOTO_ALL, 3'd2, 2'd0, 16'sd1, 0, 0, 0);
        add_command(MODE_MOVE_ALL, 3'd2, 2'd0, 16'sd1500, -16'sd20, 16'sd700, 0);
        add_command(MODE_GOTO_AXIS, 3'd2, 2'd0, 0, 0, 0, 16'sd300);
        add_command(MODE_GOTO_AXIS, 3'd2, 2'd1, 0, 0, 0, -16'sd2200);
        add_command(MODE_GOTO_AXIS, 3'd2, 2'd2, 0, 0, 0, 16'sd800);
        add_command(MODE_MOVE_AXIS, 3'd2, 2'd1, 0, 0, 0, 16'sh8000);
        add_command(MODE_MOVE_AXIS, 3'd2, 2'd1, 0, 0, 0, 16'sh7FFF);
        add_command(MODE_MOVE_AXIS, 3'd2, AXIS_NONE, 16'sh7FFF, 0, 0, 16'sh7FFF);
        add_command(MODE_GOTO_ALL, 3'd4, 2'd0, 16'sd100, 0, 0, 0);
        add_command(MODE_MOVE_AXIS, 3'd7, 2'd2, 0, 0, 0, 0);
        drain();

        // Phases over several register settings, extremes included.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_register(REG_UPPER_LEN, 16'd0);
                1:
                begin
                    write_register(REG_UPPER_LEN, 16'hFFFF);
                    write_register(REG_FORE_LEN, 16'hFFFF);
                    write_register(REG_BASE_OFF, 16'(-11520));
                    write_register(REG_SHLD_OFF, 16'(11520));
                    write_register(REG_ELBW_OFF, 16'(-11520));
                end
                2:
                begin
                    write_register(REG_UPPER_LEN, 16'd2000);
                    write_register(REG_FORE_LEN, 16'd0);
                end
                3:
                begin
                    write_register(REG_FORE_LEN, 16'd800);
                    write_register(REG_BASE_OFF, 16'(11520));
                    write_register(REG_SHLD_OFF, 16'(-11520));
                    write_register(REG_ELBW_OFF, 16'(11520));
                end
                4:
                begin
                    write_register(REG_UPPER_LEN, 16'd3);
                    write_register(REG_FORE_LEN, 16'd5);
                    write_register(REG_BASE_OFF, 16'h7FFF);
                end
                5:
                begin
                    write_register(REG_UPPER_LEN, 16'($urandom_range(1, 16000)));
                    write_register(REG_FORE_LEN, 16'($urandom_range(1, 16000)));
                    write_register(REG_BASE_OFF, 16'($signed($urandom_range(0, 23040)) - 11520));
                    write_register(REG_SHLD_OFF, 16'($signed($urandom_range(0, 23040)) - 11520));
                    write_register(REG_ELBW_OFF, 16'($signed($urandom_range(0, 23040)) - 11520));
                end
                6:
                begin
                    write_register(REG_UPPER_LEN, 16'd1600);
                    write_register(REG_FORE_LEN, 16'd1600);
                    write_register(REG_BASE_OFF, 16'd0);
                    write_register(REG_SHLD_OFF, 16'd0);
                    write_register(REG_ELBW_OFF, 16'h4000);
                end
                default:
                begin
                    write_register(REG_UPPER_LEN, 16'd12000);
                    write_register(REG_FORE_LEN, 16'd9000);
                    write_register(REG_ELBW_OFF, 16'd0);
                end
            endcase
            for (int k = 0; k < ((phase == 0 || phase == 2) ? 40 : 180); k++)
                add_random_command();
            drain();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Roughly 1180 commands, each with its sender gap and receiver stall, need under
    // 5 ms of a 2 ns clock even in the worst case; this limit sits well above that.
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
